[hw/rtl/rcmc_pkg.sv]
// Shared types, constants and command codes for the rover command motion controller.
package rcmc_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_CAL  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAMP_THR   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LAMP_MAR   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAN_STEP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_STEP = 3'd4;

    // Configuration reset values
    localparam logic [12:0] RST_RIGHT_CAL  = 13'd512;
    localparam logic [6:0]  RST_LAMP_THR   = 7'd50;
    localparam logic [4:0]  RST_LAMP_MAR   = 5'd3;
    localparam logic [12:0] RST_PAN_STEP   = 13'h300;
    localparam logic [12:0] RST_SPEED_STEP = 13'h100;

    // State reset values
    localparam logic [15:0] RST_SPEED = 16'h7000;
    localparam logic [4:0]  RST_TILT  = 5'd20;
    localparam logic [15:0] RST_PAN   = 16'hA000;

    // Limits
    localparam logic [15:0] SPEED_HIGH = 16'hC000;
    localparam logic [15:0] SPEED_LOW  = 16'h2000;
    localparam logic [15:0] LEFT_HIGH  = 16'hC000;
    localparam logic [15:0] LEFT_LOW   = 16'h2000;
    localparam logic [15:0] RIGHT_HIGH = 16'hBE00;
    localparam logic [15:0] RIGHT_LOW  = 16'h1E00;
    localparam logic [15:0] PAN_HIGH   = 16'hD000;
    localparam logic [15:0] PAN_LOW    = 16'h8000;
    localparam logic [4:0]  TILT_HIGH  = 5'd30;
    localparam logic [4:0]  TILT_LOW   = 5'd10;
    localparam logic [15:0] PWM_OFF    = 16'hFFFF;
    localparam logic [6:0]  PCT_FULL   = 7'd100;

    // ASCII command codes
    localparam logic [7:0] CHR_0 = 8'h30;
    localparam logic [7:0] CHR_1 = 8'h31;
    localparam logic [7:0] CHR_2 = 8'h32;
    localparam logic [7:0] CHR_3 = 8'h33;
    localparam logic [7:0] CHR_4 = 8'h34;
    localparam logic [7:0] CHR_5 = 8'h35;
    localparam logic [7:0] CHR_6 = 8'h36;
    localparam logic [7:0] CHR_7 = 8'h37;
    localparam logic [7:0] CHR_8 = 8'h38;
    localparam logic [7:0] CHR_D = 8'h44;
    localparam logic [7:0] CHR_F = 8'h46;
    localparam logic [7:0] CHR_U = 8'h55;

    typedef struct packed {
        logic [7:0] drive_cmd;
        logic [7:0] lamp_cmd;
        logic [7:0] camera_cmd;
        logic [7:0] speed_cmd;
        logic [6:0] light_percent;
    } in_t;

    typedef struct packed {
        logic [15:0] left_pwm;
        logic [15:0] right_pwm;
        logic        direction_pin2;
        logic        direction_pin6;
        logic        brake;
        logic        lamp_on;
        logic        servos_enabled;
        logic [4:0]  tilt_position;
        logic [15:0] pan_position;
        logic [6:0]  speed_percent;
    } out_t;

    typedef struct packed {
        logic [12:0] right_calibration;
        logic [6:0]  lamp_threshold;
        logic [4:0]  lamp_margin;
        logic [12:0] pan_step;
        logic [12:0] speed_step;
    } cfg_t;

    typedef struct packed {
        logic [15:0] speed;
        logic [4:0]  tilt;
        logic [15:0] pan;
        logic        lamp;
        logic        servo_run;
    } state_t;

endpackage

[hw/rtl/rcmc_cfg.sv]
// Configuration register file for the rover command motion controller.
module rcmc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [rcmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output rcmc_pkg::cfg_t                   cfg
);

    rcmc_pkg::cfg_t cfg_reg;
    rcmc_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                rcmc_pkg::CFG_RIGHT_CAL:  cfg_next.right_calibration = cfg_data;
                rcmc_pkg::CFG_LAMP_THR:   cfg_next.lamp_threshold    = cfg_data[6:0];
                rcmc_pkg::CFG_LAMP_MAR:   cfg_next.lamp_margin       = cfg_data[4:0];
                rcmc_pkg::CFG_PAN_STEP:   cfg_next.pan_step          = cfg_data;
                rcmc_pkg::CFG_SPEED_STEP: cfg_next.speed_step        = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.right_calibration <= rcmc_pkg::RST_RIGHT_CAL;
            cfg_reg.lamp_threshold    <= rcmc_pkg::RST_LAMP_THR;
            cfg_reg.lamp_margin       <= rcmc_pkg::RST_LAMP_MAR;
            cfg_reg.pan_step          <= rcmc_pkg::RST_PAN_STEP;
            cfg_reg.speed_step        <= rcmc_pkg::RST_SPEED_STEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/rcmc_state.sv]
// Lamp, servo and speed state registers with their per-command update logic.
module rcmc_state (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  rcmc_pkg::in_t      item,
    input  rcmc_pkg::cfg_t     cfg,
    output rcmc_pkg::state_t   st,
    output rcmc_pkg::state_t   st_next
);

    rcmc_pkg::state_t st_reg;

    logic [7:0]  light_lo;
    logic [7:0]  thr_hi;
    logic        lamp_set;
    logic        lamp_clr;
    logic [4:0]  tilt_up;
    logic [4:0]  tilt_dn;
    logic [16:0] pan_sum;
    logic [16:0] pan_floor;
    logic [15:0] pan_right;
    logic [15:0] pan_left;
    logic [16:0] spd_sum;
    logic [16:0] spd_floor;
    logic [15:0] spd_up;
    logic [15:0] spd_dn;

    // Lamp hysteresis, compared as light + margin < threshold and light > threshold + margin
    assign light_lo = {1'b0, item.light_percent} + {3'b000, cfg.lamp_margin};
    assign thr_hi   = {1'b0, cfg.lamp_threshold} + {3'b000, cfg.lamp_margin};
    assign lamp_set = (item.lamp_cmd == rcmc_pkg::CHR_F)
                   || (light_lo < {1'b0, cfg.lamp_threshold});
    assign lamp_clr = (item.lamp_cmd == rcmc_pkg::CHR_0)
                   && ({1'b0, item.light_percent} > thr_hi);

    assign tilt_up = (st_reg.tilt + 5'd1 >= rcmc_pkg::TILT_HIGH) ? rcmc_pkg::TILT_HIGH
                                                                 : st_reg.tilt + 5'd1;
    assign tilt_dn = (st_reg.tilt <= rcmc_pkg::TILT_LOW + 5'd1) ? rcmc_pkg::TILT_LOW
                                                                : st_reg.tilt - 5'd1;

    assign pan_sum   = {1'b0, st_reg.pan} + {4'b0000, cfg.pan_step};
    assign pan_floor = {1'b0, rcmc_pkg::PAN_LOW} + {4'b0000, cfg.pan_step};
    assign pan_right = (pan_sum > {1'b0, rcmc_pkg::PAN_HIGH}) ? rcmc_pkg::PAN_HIGH
                                                              : pan_sum[15:0];
    assign pan_left  = ({1'b0, st_reg.pan} < pan_floor) ? rcmc_pkg::PAN_LOW
                                                        : st_reg.pan - {3'b000, cfg.pan_step};

    assign spd_sum   = {1'b0, st_reg.speed} + {4'b0000, cfg.speed_step};
    assign spd_floor = {1'b0, rcmc_pkg::SPEED_LOW} + {4'b0000, cfg.speed_step};
    assign spd_up    = (spd_sum > {1'b0, rcmc_pkg::SPEED_HIGH}) ? rcmc_pkg::SPEED_HIGH
                                                                : spd_sum[15:0];
    assign spd_dn    = ({1'b0, st_reg.speed} < spd_floor) ? rcmc_pkg::SPEED_LOW
                                                          : st_reg.speed - {3'b000, cfg.speed_step};

    always_comb
    begin
        st_next = st_reg;

        if (lamp_set)
        begin
            st_next.lamp = 1'b1;
        end
        else if (lamp_clr)
        begin
            st_next.lamp = 1'b0;
        end

        st_next.servo_run = (item.camera_cmd != rcmc_pkg::CHR_0);

        case (item.camera_cmd)
            rcmc_pkg::CHR_1: st_next.tilt = tilt_up;
            rcmc_pkg::CHR_2: st_next.tilt = tilt_dn;
            rcmc_pkg::CHR_3: st_next.pan  = pan_left;
            rcmc_pkg::CHR_4: st_next.pan  = pan_right;
            rcmc_pkg::CHR_5:
            begin
                st_next.pan  = pan_left;
                st_next.tilt = tilt_up;
            end
            rcmc_pkg::CHR_6:
            begin
                st_next.pan  = pan_right;
                st_next.tilt = tilt_up;
            end
            rcmc_pkg::CHR_7:
            begin
                st_next.pan  = pan_left;
                st_next.tilt = tilt_dn;
            end
            rcmc_pkg::CHR_8:
            begin
                st_next.pan  = pan_right;
                st_next.tilt = tilt_dn;
            end
            default: st_next.pan = st_reg.pan;
        endcase

        case (item.speed_cmd)
            rcmc_pkg::CHR_D: st_next.speed = spd_up;
            rcmc_pkg::CHR_U: st_next.speed = spd_dn;
            default:         st_next.speed = st_reg.speed;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.speed     <= rcmc_pkg::RST_SPEED;
            st_reg.tilt      <= rcmc_pkg::RST_TILT;
            st_reg.pan       <= rcmc_pkg::RST_PAN;
            st_reg.lamp      <= 1'b0;
            st_reg.servo_run <= 1'b0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

[hw/rtl/rcmc_drive.sv]
// Drive decode, PWM clamping and speed percentage for one result.
module rcmc_drive (
    input  logic [7:0]        drive_cmd,
    input  rcmc_pkg::state_t  st_next,
    input  logic [12:0]       right_calibration,
    output rcmc_pkg::out_t    result
);

    function automatic logic [15:0] clamp_pwm(input logic [15:0] v,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [15:0] r;
        begin
            if (v == rcmc_pkg::PWM_OFF)
                r = v;
            else if (v < lo)
                r = lo;
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

    logic [15:0] fast;
    logic [15:0] left_raw;
    logic [15:0] right_raw;
    logic        d2;
    logic        d6;
    logic        brk;
    logic [15:0] span;
    logic [17:0] span_x5;
    logic [6:0]  span_pct;

    // Setting never exceeds the speed ceiling, so the sum stays below the off code
    assign fast = st_next.speed + {3'b000, right_calibration};

    always_comb
    begin
        left_raw  = 16'h0000;
        right_raw = 16'h0000;
        d2        = 1'b0;
        d6        = 1'b0;
        brk       = 1'b0;
        case (drive_cmd)
            rcmc_pkg::CHR_0:
            begin
                d2 = 1'b1; d6 = 1'b1; brk = 1'b1;
                left_raw = rcmc_pkg::PWM_OFF; right_raw = rcmc_pkg::PWM_OFF;
            end
            rcmc_pkg::CHR_1:
            begin
                d2 = 1'b1; d6 = 1'b1;
                left_raw = st_next.speed; right_raw = fast;
            end
            rcmc_pkg::CHR_2:
            begin
                left_raw = st_next.speed; right_raw = fast;
            end
            rcmc_pkg::CHR_3:
            begin
                d6 = 1'b1;
                left_raw = st_next.speed; right_raw = fast;
            end
            rcmc_pkg::CHR_4:
            begin
                d2 = 1'b1;
                left_raw = st_next.speed; right_raw = fast;
            end
            rcmc_pkg::CHR_5:
            begin
                d2 = 1'b1; d6 = 1'b1;
                left_raw = rcmc_pkg::PWM_OFF; right_raw = fast;
            end
            rcmc_pkg::CHR_6:
            begin
                d2 = 1'b1; d6 = 1'b1;
                left_raw = st_next.speed; right_raw = rcmc_pkg::PWM_OFF;
            end
            rcmc_pkg::CHR_7:
            begin
                left_raw = st_next.speed; right_raw = rcmc_pkg::PWM_OFF;
            end
            rcmc_pkg::CHR_8:
            begin
                left_raw = rcmc_pkg::PWM_OFF; right_raw = fast;
            end
            default:
            begin
                left_raw  = 16'h0000;
                right_raw = 16'h0000;
            end
        endcase
    end

    // Span * 100 / 0xA000 reduces to span * 5 / 2048
    assign span     = st_next.speed - rcmc_pkg::SPEED_LOW;
    assign span_x5  = {span, 2'b00} + {2'b00, span};
    assign span_pct = span_x5[17:11];

    always_comb
    begin
        result.left_pwm       = clamp_pwm(left_raw, rcmc_pkg::LEFT_LOW, rcmc_pkg::LEFT_HIGH);
        result.right_pwm      = clamp_pwm(right_raw, rcmc_pkg::RIGHT_LOW, rcmc_pkg::RIGHT_HIGH);
        result.direction_pin2 = d2;
        result.direction_pin6 = d6;
        result.brake          = brk;
        result.lamp_on        = st_next.lamp;
        result.servos_enabled = st_next.servo_run;
        result.tilt_position  = st_next.tilt;
        result.pan_position   = st_next.pan;
        result.speed_percent  = rcmc_pkg::PCT_FULL - span_pct;
    end

endmodule

[hw/rtl/rover_command_motion_controller_unit.sv]
// Rover command motion controller top level: input register, update logic, result register.
// An accepted transaction is held in the input register, then its result is loaded into the
// result register that drives out_data once that register is free.
// Throughput: one transaction per cycle; the input register and result register both advance
// each cycle unless the result register is held by out_ready low.
// Reset (rst_n low, asynchronous): pipeline empties, configuration and state return to
// their defaults (speed 0x7000, tilt 20, pan 0xA000, lamp off, servos disabled).
module rover_command_motion_controller_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  rcmc_pkg::in_t                    in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output rcmc_pkg::out_t                   out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rcmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic             s1_valid_reg;
    rcmc_pkg::in_t    s1_data_reg;
    logic             out_valid_reg;
    rcmc_pkg::out_t   out_data_reg;
    logic             advance;
    rcmc_pkg::cfg_t   cfg;
    rcmc_pkg::state_t st;
    rcmc_pkg::state_t st_next;
    rcmc_pkg::out_t   result;

    assign cfg_ready = 1'b1;

    // Move the held transaction into the result register when that slot frees up
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    rcmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcmc_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_data_reg),
        .cfg     (cfg),
        .st      (st),
        .st_next (st_next)
    );

    rcmc_drive u_drive (
        .drive_cmd         (s1_data_reg.drive_cmd),
        .st_next           (st_next),
        .right_calibration (cfg.right_calibration),
        .result            (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A moved transaction always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    // Input side stalls only when both stages are full and the output is held
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a full pipeline");

    // State changes only when a transaction is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st))
        else $error("state changed without a transaction");

    // Brake always comes with both motors off
    a_brake_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.brake) |->
            (out_data_reg.left_pwm == rcmc_pkg::PWM_OFF
             && out_data_reg.right_pwm == rcmc_pkg::PWM_OFF))
        else $error("brake set with a motor driven");

endmodule

[sim/tb_rover_command_motion_controller_unit.sv]
// Self-checking testbench for the rover command motion controller unit.
module tb_rover_command_motion_controller_unit;
    import rcmc_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int REPORT_MAX = 10;
    localparam int CMDS_PER_SETUP = 140;
    localparam int NUM_SETUPS = 7;
    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
    } setting_write_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    in_t                    in_data = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    out_t                   out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Predicted configuration and rover state
    logic [12:0] right_cal = RST_RIGHT_CAL;
    logic [6:0]  lamp_thr = RST_LAMP_THR;
    logic [4:0]  lamp_mar = RST_LAMP_MAR;
    logic [12:0] pan_inc = RST_PAN_STEP;
    logic [12:0] speed_inc = RST_SPEED_STEP;
    logic [15:0] speed_now = RST_SPEED;
    logic [4:0]  tilt_now = RST_TILT;
    logic [15:0] pan_now = RST_PAN;
    logic        lamp_now = 1'b0;
    logic        servo_now = 1'b0;

    in_t            cmd_backlog[$];
    setting_write_t setting_writes[$];
    out_t           motion_expected[$];

    int   mismatches = 0;
    int   results_checked = 0;
    int   cmds_accepted = 0;
    int   stuck_cycles = 0;
    int   in_gap = 0;
    int   out_gap = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   speed_up_pct = 50;
    logic no_idle = 1'b0;

    rover_command_motion_controller_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void apply_setting(logic [CFG_INDEX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_RIGHT_CAL:  right_cal = val;
            CFG_LAMP_THR:   lamp_thr = val[6:0];
            CFG_LAMP_MAR:   lamp_mar = val[4:0];
            CFG_PAN_STEP:   pan_inc = val;
            CFG_SPEED_STEP: speed_inc = val;
            default: ;
        endcase
    endfunction

    function automatic void tilt_by(int dir);
        if (dir > 0)
            tilt_now = (tilt_now + 5'd1 >= TILT_HIGH) ? TILT_HIGH : tilt_now + 5'd1;
        else
            tilt_now = (tilt_now <= TILT_LOW + 5'd1) ? TILT_LOW : tilt_now - 5'd1;
    endfunction

    function automatic void pan_by(int dir);
        int sum;
        sum = int'(pan_now) + int'(pan_inc);
        if (dir > 0)
            pan_now = (sum > int'(PAN_HIGH)) ? PAN_HIGH : sum[15:0];
        else
            pan_now = (int'(pan_now) < int'(PAN_LOW) + int'(pan_inc)) ? PAN_LOW
                                                        : pan_now - {3'b000, pan_inc};
    endfunction

    function automatic logic [15:0] clamp_pwm(int v, int lo, int hi);
        int r;
        r = v;
        if (v != int'(PWM_OFF))
        begin
            if (v < lo)
                r = lo;
            else if (v > hi)
                r = hi;
        end
        return r[15:0];
    endfunction

    // Advance the rover state by one command and return the expected result
    function automatic out_t advance_rover(in_t c);
        out_t r;
        int   light;
        int   fast;
        int   left;
        int   right;
        int   pct;
        light = int'(c.light_percent);
        if (c.lamp_cmd == CHR_F || light < int'(lamp_thr) - int'(lamp_mar))
            lamp_now = 1'b1;
        else if (c.lamp_cmd == CHR_0 && light > int'(lamp_thr) + int'(lamp_mar))
            lamp_now = 1'b0;

        servo_now = (c.camera_cmd != CHR_0);
        case (c.camera_cmd)
            CHR_1: tilt_by(1);
            CHR_2: tilt_by(-1);
            CHR_3: pan_by(-1);
            CHR_4: pan_by(1);
            CHR_5:
            begin
                pan_by(-1);
                tilt_by(1);
            end
            CHR_6:
            begin
                pan_by(1);
                tilt_by(1);
            end
            CHR_7:
            begin
                pan_by(-1);
                tilt_by(-1);
            end
            CHR_8:
            begin
                pan_by(1);
                tilt_by(-1);
            end
            default: ;
        endcase

        if (c.speed_cmd == CHR_D)
            speed_now = (int'(speed_now) + int'(speed_inc) > int'(SPEED_HIGH))
                        ? SPEED_HIGH : speed_now + {3'b000, speed_inc};
        else if (c.speed_cmd == CHR_U)
            speed_now = (int'(speed_now) < int'(SPEED_LOW) + int'(speed_inc))
                        ? SPEED_LOW : speed_now - {3'b000, speed_inc};

        r = '0;
        left = 0;
        right = 0;
        fast = int'(speed_now) + int'(right_cal);
        case (c.drive_cmd)
            CHR_0:
            begin
                {r.direction_pin2, r.direction_pin6, r.brake} = 3'b111;
                left = int'(PWM_OFF);
                right = int'(PWM_OFF);
            end
            CHR_1:
            begin
                {r.direction_pin2, r.direction_pin6} = 2'b11;
                left = int'(speed_now);
                right = fast;
            end
            CHR_2:
            begin
                left = int'(speed_now);
                right = fast;
            end
            CHR_3:
            begin
                r.direction_pin6 = 1'b1;
                left = int'(speed_now);
                right = fast;
            end
            CHR_4:
            begin
                r.direction_pin2 = 1'b1;
                left = int'(speed_now);
                right = fast;
            end
            CHR_5:
            begin
                {r.direction_pin2, r.direction_pin6} = 2'b11;
                left = int'(PWM_OFF);
                right = fast;
            end
            CHR_6:
            begin
                {r.direction_pin2, r.direction_pin6} = 2'b11;
                left = int'(speed_now);
                right = int'(PWM_OFF);
            end
            CHR_7:
            begin
                left = int'(speed_now);
                right = int'(PWM_OFF);
            end
            CHR_8:
            begin
                left = int'(PWM_OFF);
                right = fast;
            end
            default: ;
        endcase
        r.left_pwm = clamp_pwm(left, int'(LEFT_LOW), int'(LEFT_HIGH));
        r.right_pwm = clamp_pwm(right, int'(RIGHT_LOW), int'(RIGHT_HIGH));
        r.lamp_on = lamp_now;
        r.servos_enabled = servo_now;
        r.tilt_position = tilt_now;
        r.pan_position = pan_now;
        pct = int'(PCT_FULL) - (int'(speed_now) - int'(SPEED_LOW)) * int'(PCT_FULL)
              / (int'(SPEED_HIGH) - int'(SPEED_LOW));
        r.speed_percent = pct[6:0];
        return r;
    endfunction

    function automatic string diff_fields(out_t w, out_t g);
        string s;
        s = "";
        if (g.left_pwm !== w.left_pwm) s = {s, " left_pwm"};
        if (g.right_pwm !== w.right_pwm) s = {s, " right_pwm"};
        if (g.direction_pin2 !== w.direction_pin2) s = {s, " direction_pin2"};
        if (g.direction_pin6 !== w.direction_pin6) s = {s, " direction_pin6"};
        if (g.brake !== w.brake) s = {s, " brake"};
        if (g.lamp_on !== w.lamp_on) s = {s, " lamp_on"};
        if (g.servos_enabled !== w.servos_enabled) s = {s, " servos_enabled"};
        if (g.tilt_position !== w.tilt_position) s = {s, " tilt_position"};
        if (g.pan_position !== w.pan_position) s = {s, " pan_position"};
        if (g.speed_percent !== w.speed_percent) s = {s, " speed_percent"};
        return s;
    endfunction

    function automatic string show(out_t r);
        return $sformatf("L=%h R=%h d2=%b d6=%b brk=%b lamp=%b srv=%b tilt=%0d pan=%h pct=%0d",
                         r.left_pwm, r.right_pwm, r.direction_pin2, r.direction_pin6,
                         r.brake, r.lamp_on, r.servos_enabled, r.tilt_position,
                         r.pan_position, r.speed_percent);
    endfunction

    // Mostly well-formed commands with lights near the lamp switching points
    function automatic in_t draw_cmd();
        in_t c;
        int  near;
        c.drive_cmd = 8'($urandom);
        c.lamp_cmd = 8'($urandom);
        c.camera_cmd = 8'($urandom);
        c.speed_cmd = 8'($urandom);
        c.light_percent = 7'($urandom_range(127, 0));
        if ($urandom_range(99, 0) < 85)
        begin
            if ($urandom_range(9, 0) != 0)
                c.drive_cmd = CHR_0 + 8'($urandom_range(8, 0));
            case ($urandom_range(3, 0))
                0: c.lamp_cmd = CHR_F;
                1, 2: c.lamp_cmd = CHR_0;
                default: ;
            endcase
            if ($urandom_range(9, 0) != 0)
                c.camera_cmd = CHR_0 + 8'($urandom_range(8, 0));
            if ($urandom_range(9, 0) != 0)
                c.speed_cmd = ($urandom_range(99, 0) < speed_up_pct) ? CHR_D : CHR_U;
            if ($urandom_range(1, 0) != 0)
            begin
                near = ($urandom_range(1, 0) != 0) ? int'(lamp_thr) - int'(lamp_mar)
                                                   : int'(lamp_thr) + int'(lamp_mar);
                near = near + int'($urandom_range(2, 0)) - 1;
                if (near < 0)
                    near = 0;
                else if (near > 127)
                    near = 127;
                c.light_percent = near[6:0];
            end
            else
                c.light_percent = 7'($urandom_range(100, 0));
        end
        return c;
    endfunction

    task automatic queue_cmd(logic [7:0] drive, logic [7:0] lamp, logic [7:0] cam,
                             logic [7:0] spd, logic [6:0] light);
        cmd_backlog.push_back('{drive, lamp, cam, spd, light});
    endtask

    // Wait until every transaction is through and every result has been checked
    task automatic drain();
        while (cmd_backlog.size() != 0 || in_valid || motion_expected.size() != 0
               || setting_writes.size() != 0 || cfg_valid)
            @(negedge clk);
    endtask

    task automatic load_settings(cfg_t s);
        setting_writes.push_back('{CFG_SPARE_LO, CFG_DATA_W'($urandom)});
        setting_writes.push_back('{CFG_RIGHT_CAL, s.right_calibration});
        setting_writes.push_back('{CFG_LAMP_THR, CFG_DATA_W'(s.lamp_threshold)});
        setting_writes.push_back('{CFG_LAMP_MAR, CFG_DATA_W'(s.lamp_margin)});
        setting_writes.push_back('{CFG_PAN_STEP, s.pan_step});
        setting_writes.push_back('{CFG_SPEED_STEP, s.speed_step});
        setting_writes.push_back('{CFG_SPARE_HI, CFG_DATA_W'($urandom)});
        drain();
    endtask

    always @(posedge clk)
    begin : driver
        setting_write_t w;
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    in_data <= cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (!no_idle && $urandom_range(99, 0) < gap_pct)
                        in_gap <= $urandom_range(7, 1);
                end
                else
                    in_valid <= 1'b0;
            end

            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!no_idle && $urandom_range(99, 0) < stall_pct)
            begin
                out_gap <= $urandom_range(6, 0);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;

            if (!cfg_valid || cfg_ready)
            begin
                if (setting_writes.size() != 0)
                begin
                    w = setting_writes.pop_front();
                    cfg_index <= w.idx;
                    cfg_data <= w.val;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        out_t  want;
        string diffs;
        logic  moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                apply_setting(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                motion_expected.push_back(advance_rover(in_data));
                cmds_accepted++;
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                results_checked++;
                if (motion_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: %s", show(out_data));
                end
                else
                begin
                    want = motion_expected.pop_front();
                    diffs = diff_fields(want, out_data);
                    if (diffs != "")
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("result %0d differs in%s", results_checked, diffs);
                            $display("  expected %s", show(want));
                            $display("  actual   %s", show(out_data));
                        end
                    end
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STUCK_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        cfg_t setup;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed commands at the reset settings (threshold 50, margin 3)
        gap_pct = 20;
        stall_pct = 20;
        queue_cmd(8'h00, 8'h00, 8'h00, 8'h00, 7'd0);
        queue_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'h7F);
        queue_cmd(CHR_0, CHR_0, CHR_0, CHR_D, 7'd100);
        queue_cmd(CHR_1, CHR_F, CHR_1, CHR_U, 7'd100);
        queue_cmd(CHR_2, CHR_0, CHR_2, CHR_D, 7'd46);
        queue_cmd(CHR_3, CHR_0, CHR_3, CHR_U, 7'd54);
        queue_cmd(CHR_4, CHR_0, CHR_4, CHR_D, 7'd47);
        queue_cmd(CHR_5, CHR_F, CHR_5, CHR_U, 7'd53);
        queue_cmd(CHR_6, CHR_0, CHR_6, CHR_D, 7'd53);
        queue_cmd(CHR_7, CHR_0, CHR_7, CHR_U, 7'd50);
        queue_cmd(CHR_8, CHR_0, CHR_8, CHR_D, 7'd54);
        queue_cmd(CHR_D, CHR_U, CHR_U, CHR_F, 7'd60);
        queue_cmd(CHR_0, CHR_1, CHR_0, CHR_0, 7'd20);
        queue_cmd(CHR_6, CHR_D, CHR_6, CHR_D, 7'd100);
        queue_cmd(CHR_7, CHR_0, CHR_7, CHR_U, 7'd101);
        queue_cmd(CHR_8, CHR_F, CHR_8, CHR_D, 7'd0);
        queue_cmd(CHR_5, CHR_0, CHR_5, CHR_U, 7'd127);
        queue_cmd(CHR_1, CHR_0, CHR_2, CHR_D, 7'd64);
        drain();

        for (int p = 0; p < NUM_SETUPS; p++)
        begin
            case (p)
                0: setup = {RST_RIGHT_CAL, RST_LAMP_THR, RST_LAMP_MAR,
                            RST_PAN_STEP, RST_SPEED_STEP};
                1: setup = '0;
                2: setup = {13'd4096, 7'd100, 5'd20, 13'd4096, 13'd4096};
                3: setup = '1;
                // threshold under the margin: light alone never lights the lamp
                4: setup = {13'($urandom_range(4096, 0)), 7'd4, 5'd17,
                            13'($urandom_range(4096, 0)), 13'($urandom_range(4096, 0))};
                default: setup = {13'($urandom_range(4096, 0)), 7'($urandom_range(100, 0)),
                                  5'($urandom_range(20, 0)), 13'($urandom_range(4096, 0)),
                                  13'($urandom_range(4096, 0))};
            endcase
            no_idle = (p == NUM_SETUPS - 1);
            gap_pct = (p % 3) * 20;
            stall_pct = ((p + 1) % 3) * 20;
            speed_up_pct = (p % 2 != 0) ? 75 : 25;
            load_settings(setup);
            for (int n = 0; n < CMDS_PER_SETUP; n++)
                cmd_backlog.push_back(draw_cmd());
            drain();
        end

        repeat (4) @(negedge clk);
        if (motion_expected.size() != 0)
        begin
            mismatches += motion_expected.size();
            $display("%0d expected results never arrived", motion_expected.size());
        end
        $display("covered %0d commands under %0d register settings, %0d results checked",
                 cmds_accepted, NUM_SETUPS, results_checked);
        $display("lamp hysteresis, servo and speed limits, all drive codes; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
